FILE: design/bdq_pkg.sv
// bdq_pkg: shared types, codes and constants for the bounded deque
// used by bdq_front, bdq_queue, bdq_back and bounded_deque_with_eviction
package bdq_pkg;

  // defaults
  localparam int          DEPTH_DEFAULT = 128;
  localparam logic [7:0]  LIMIT_RESET   = 8'd100;

  // field widths
  localparam int CMD_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 8;
  localparam int LIMIT_W  = 8;

  // packed stream widths, padded to whole bytes
  localparam int IN_W  = ((CMD_W + VALUE_W + 7) / 8) * 8;
  localparam int OUT_W = ((STATUS_W + VALUE_W + COUNT_W + 7) / 8) * 8;

  // command codes on the input stream
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_MIDDLE     = 3'd4;

  // status codes on the output stream
  localparam logic [STATUS_W-1:0] ST_PUSHED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_POPPED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EVICTED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MIDDLE  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NONE    = 3'd4;

  // decoded operation kind
  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_MIDDLE,
    OP_NONE
  } op_kind_t;

  // one decoded word travelling from front to back
  typedef struct packed {
    op_kind_t            kind;
    logic [VALUE_W-1:0]  value;
  } op_t;

endpackage

FILE: design/bdq_front.sv
// bdq_front: accepts input words, decodes the command, holds one decoded op
// depends on bdq_pkg
module bdq_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [bdq_pkg::CMD_W-1:0]  in_command,
  input  logic [bdq_pkg::VALUE_W-1:0] in_value,
  output logic                       op_valid,
  input  logic                       op_ready,
  output bdq_pkg::op_t               op
);

  bdq_pkg::op_kind_t kind_dec;

  // command decode, unknown codes become a no-op
  always_comb begin
    unique case (in_command)
      bdq_pkg::CMD_PUSH_FRONT: kind_dec = bdq_pkg::OP_PUSH_FRONT;
      bdq_pkg::CMD_PUSH_BACK:  kind_dec = bdq_pkg::OP_PUSH_BACK;
      bdq_pkg::CMD_POP_FRONT:  kind_dec = bdq_pkg::OP_POP_FRONT;
      bdq_pkg::CMD_POP_BACK:   kind_dec = bdq_pkg::OP_POP_BACK;
      bdq_pkg::CMD_MIDDLE:     kind_dec = bdq_pkg::OP_MIDDLE;
      default:                 kind_dec = bdq_pkg::OP_NONE;
    endcase
  end

  assign in_ready = !op_valid || op_ready;

  // decoded op register
  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (in_ready) begin
      op_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op.kind  <= kind_dec;
      op.value <= in_value;
    end
  end

endmodule

FILE: design/bdq_queue.sv
// bdq_queue: two-entry queue of decoded ops between front and back
// depends on bdq_pkg
module bdq_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  bdq_pkg::op_t wr_op,
  output logic         rd_valid,
  input  logic         rd_ready,
  output bdq_pkg::op_t rd_op
);

  bdq_pkg::op_t slots [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   fill;
  logic         do_wr;
  logic         do_rd;

  assign wr_ready = (fill != 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_op    = slots[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_wr) wr_ptr <= ~wr_ptr;
      if (do_rd) rd_ptr <= ~rd_ptr;
      if (do_wr && !do_rd) begin
        fill <= fill + 2'd1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 2'd1;
      end
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_op;
  end

endmodule

FILE: design/bdq_back.sv
// bdq_back: ring store, head pointer and count; executes one op per cycle while the result output is not stalled
// depends on bdq_pkg
module bdq_back #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [bdq_pkg::LIMIT_W-1:0]   cfg_wr_data,
  input  logic                          op_valid,
  output logic                          op_ready,
  input  bdq_pkg::op_t                  op,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [bdq_pkg::STATUS_W-1:0]  res_status,
  output logic [bdq_pkg::VALUE_W-1:0]   res_value,
  output logic [bdq_pkg::COUNT_W-1:0]   res_count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int LW = (CW > bdq_pkg::LIMIT_W) ? CW : bdq_pkg::LIMIT_W;

  logic [bdq_pkg::VALUE_W-1:0] ring [DEPTH];
  logic [AW-1:0]               head;
  logic [CW-1:0]               count;
  logic [bdq_pkg::LIMIT_W-1:0] limit;

  // result holding register, read data comes from the ring read register
  logic                          pend_use_rd;
  logic [bdq_pkg::STATUS_W-1:0]  pend_status;
  logic [bdq_pkg::COUNT_W-1:0]   pend_count;
  logic [bdq_pkg::VALUE_W-1:0]   rd_data;

  logic                          fire;
  logic                          full;
  logic                          evict;
  logic [CW-1:0]                 offset;
  logic [SW-1:0]                 sum;
  logic [AW-1:0]                 wrap_pos;
  logic [AW-1:0]                 head_dec;
  logic [AW-1:0]                 rd_addr;
  logic                          rd_en;
  logic [AW-1:0]                 wr_addr;
  logic                          wr_en;
  logic [AW-1:0]                 head_next;
  logic [CW-1:0]                 count_next;
  logic [bdq_pkg::STATUS_W-1:0]  status_next;

  assign op_ready = !res_valid || res_ready;
  assign fire     = op_valid && op_ready;

  // limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= bdq_pkg::LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit <= cfg_wr_data;
    end
  end

  // eviction test against the limit clamped to one..DEPTH
  assign full  = (count == CW'(DEPTH));
  assign evict = (count != '0) && (full || (LW'(count) >= LW'(limit)));

  // one shared ring position adder
  always_comb begin
    case (op.kind)
      bdq_pkg::OP_PUSH_BACK:  offset = evict ? '0 : count;
      bdq_pkg::OP_PUSH_FRONT: offset = count - CW'(1);
      bdq_pkg::OP_POP_FRONT:  offset = '0;
      bdq_pkg::OP_POP_BACK:   offset = count - CW'(1);
      bdq_pkg::OP_MIDDLE:     offset = (count - CW'(1)) >> 1;
      default:                offset = '0;
    endcase
  end

  assign sum      = SW'(head) + SW'(offset);
  assign wrap_pos = (sum >= SW'(DEPTH)) ? AW'(sum - SW'(DEPTH)) : AW'(sum);
  assign head_dec = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);

  // tail position for a push at the back, head plus count
  logic [SW-1:0] tail_sum;
  logic [AW-1:0] tail_pos;
  logic [AW-1:0] head_inc;
  assign tail_sum = SW'(head) + SW'(count);
  assign tail_pos = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH))
                                             : AW'(tail_sum);
  assign head_inc = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);

  // op execution plan
  always_comb begin
    rd_en       = 1'b0;
    rd_addr     = wrap_pos;
    wr_en       = 1'b0;
    wr_addr     = tail_pos;
    head_next   = head;
    count_next  = count;
    status_next = bdq_pkg::ST_NONE;
    unique case (op.kind)
      bdq_pkg::OP_PUSH_FRONT: begin
        wr_en     = 1'b1;
        wr_addr   = head_dec;
        head_next = head_dec;
        if (evict) begin
          rd_en       = 1'b1;
          status_next = bdq_pkg::ST_EVICTED;
        end else begin
          count_next  = count + CW'(1);
          status_next = bdq_pkg::ST_PUSHED;
        end
      end
      bdq_pkg::OP_PUSH_BACK: begin
        wr_en   = 1'b1;
        wr_addr = tail_pos;
        if (evict) begin
          rd_en       = 1'b1;
          head_next   = head_inc;
          status_next = bdq_pkg::ST_EVICTED;
        end else begin
          count_next  = count + CW'(1);
          status_next = bdq_pkg::ST_PUSHED;
        end
      end
      bdq_pkg::OP_POP_FRONT: begin
        if (count != '0) begin
          rd_en       = 1'b1;
          head_next   = head_inc;
          count_next  = count - CW'(1);
          status_next = bdq_pkg::ST_POPPED;
        end
      end
      bdq_pkg::OP_POP_BACK: begin
        if (count != '0) begin
          rd_en       = 1'b1;
          count_next  = count - CW'(1);
          status_next = bdq_pkg::ST_POPPED;
        end
      end
      bdq_pkg::OP_MIDDLE: begin
        if (count >= CW'(2)) begin
          rd_en       = 1'b1;
          status_next = bdq_pkg::ST_MIDDLE;
        end
      end
      default: begin
        status_next = bdq_pkg::ST_NONE;
      end
    endcase
  end

  // pointer state
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (fire) begin
      head  <= head_next;
      count <= count_next;
    end
  end

  // ring store, read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (fire && rd_en) rd_data <= ring[rd_addr];
    if (fire && wr_en) ring[wr_addr] <= op.value;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (op_ready) begin
      res_valid <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pend_use_rd <= rd_en;
      pend_status <= status_next;
      pend_count  <= bdq_pkg::COUNT_W'(count_next);
    end
  end

  assign res_status = pend_status;
  assign res_value  = pend_use_rd ? rd_data : '0;
  assign res_count  = pend_count;

endmodule

FILE: design/bounded_deque_with_eviction.sv
// bounded_deque_with_eviction: top level, stream ports and limit register port
// depends on bdq_pkg, bdq_front, bdq_queue, bdq_back
// path: an accepted input word passes the front op register, the queue slots and the result register
// throughput: one word per cycle while the output stream is not stalled
// the ring store does at most one read and one write per cycle; results wait in a register
// reset: head and count clear, limit returns to 100, ring contents stay unknown
module bounded_deque_with_eviction #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [bdq_pkg::LIMIT_W-1:0]  cfg_wr_data,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // command [2:0], push_value [34:3], zero pad above
  input  logic [bdq_pkg::IN_W-1:0]     s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // status [2:0], out_value [34:3], element_count [42:35], zero pad above
  output logic [bdq_pkg::OUT_W-1:0]    m_axis_tdata
);

  localparam int VAL_LO = bdq_pkg::CMD_W;
  localparam int PAD_W  = bdq_pkg::OUT_W - bdq_pkg::STATUS_W - bdq_pkg::VALUE_W
                          - bdq_pkg::COUNT_W;

  logic                          f_valid;
  logic                          f_ready;
  bdq_pkg::op_t                  f_op;
  logic                          q_valid;
  logic                          q_ready;
  bdq_pkg::op_t                  q_op;
  logic [bdq_pkg::STATUS_W-1:0]  status;
  logic [bdq_pkg::VALUE_W-1:0]   out_value;
  logic [bdq_pkg::COUNT_W-1:0]   element_count;

  // front: accept and decode
  bdq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_command (s_axis_tdata[bdq_pkg::CMD_W-1:0]),
    .in_value   (s_axis_tdata[VAL_LO +: bdq_pkg::VALUE_W]),
    .op_valid   (f_valid),
    .op_ready   (f_ready),
    .op         (f_op)
  );

  // queue between front and back
  bdq_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_op    (f_op),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_op    (q_op)
  );

  // back: ring store execution
  bdq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .op_valid    (q_valid),
    .op_ready    (q_ready),
    .op          (q_op),
    .res_valid   (m_axis_tvalid),
    .res_ready   (m_axis_tready),
    .res_status  (status),
    .res_value   (out_value),
    .res_count   (element_count)
  );

  // pack result word
  assign m_axis_tdata = {{PAD_W{1'b0}}, element_count, out_value, status};

endmodule
